[sv/upd_pkg.sv]
// Shared types, constants and helpers of the URI path percent decoder.
// No dependencies; the controller, the datapath, the top level and the checkers import it.
package upd_pkg;

	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	localparam logic [63:0] PFX_FILE3 = "file:///";
	localparam logic [55:0] PFX_FILE2 = "file://";
	localparam logic [47:0] PFX_FILE1 = "file:/";

	typedef enum logic [1:0] {
		PP_NONE  = 2'd0,
		PP_PCT   = 2'd1,
		PP_HEX1  = 2'd2,
		PP_FLUSH = 2'd3
	} upd_pp_e;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_START,
		CMD_BODY,
		CMD_REP,
		CMD_FIN,
		CMD_FIN2,
		CMD_EMPTY
	} upd_cmd_e;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_REPLAY,
		ST_BODY,
		ST_FIN,
		ST_FIN2,
		ST_EMPTY
	} upd_state_e;

	typedef struct packed {
		logic ok;
		logic byte_done;
		logic start_end;
		logic k_end;
		logic in_body;
		logic wc_zero;
		logic win_full;
		logic pp_zero;
		logic fin_two;
		logic end_flag;
		logic new_last;
		logic new_end;
	} upd_stat_t;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
			(c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] v;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c - 8'h30;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = c - 8'h57;
		end else begin
			v = c - 8'h37;
		end
		return v[3:0];
	endfunction

endpackage

[sv/upd_ifs.sv]
// Stream interfaces of the URI path percent decoder: URI bytes in, path bytes out.
// No dependencies.
interface upd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       last_in;
	logic       end_only;

	modport source (output valid, char_in, last_in, end_only, input ready);
	modport sink (input valid, char_in, last_in, end_only, output ready);
endinterface

interface upd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_out;
	logic       last_out;
	logic       empty_string;

	modport source (output valid, char_out, last_out, empty_string, input ready);
	modport sink (input valid, char_out, last_out, empty_string, output ready);
endinterface

[sv/upd_datapath.sv]
// Datapath: prefix window, escape decoding, held path byte and output register.
// Depends on upd_pkg; driven by upd_ctrl through command and status.
module upd_datapath #(
	parameter int unsigned PREFIX_WINDOW = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  upd_pkg::upd_cmd_e cmd,
	output upd_pkg::upd_stat_t stat,
	input  logic [7:0]        char_in,
	input  logic              last_in,
	input  logic              end_only,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [7:0]        char_out,
	output logic              last_out,
	output logic              empty_string
);
	import upd_pkg::*;

	localparam int unsigned CW = $clog2(PREFIX_WINDOW + 1);
	localparam int unsigned IW = $clog2(PREFIX_WINDOW);

	logic [7:0]    win_q [PREFIX_WINDOW];
	logic [CW-1:0] wc_q;
	logic [CW-1:0] k_q;
	logic          body_q;
	upd_pp_e       pp_q;
	logic          held_q;
	logic [7:0]    le_q;
	logic [7:0]    fhd_q;
	logic [7:0]    cur_q;
	logic          last_q;
	logic          end_q;
	logic          wm_q;
	logic          ov_q;
	logic [7:0]    oc_q;
	logic          ol_q;
	logic          oe_q;

	logic [7:0]    ns;
	logic [7:0]    fs;
	logic [7:0]    src;
	logic          hx;
	logic          em;
	logic [7:0]    eb;
	upd_pp_e       pp_n;
	logic          done;
	logic          fhd_ld;
	logic          put;
	logic [7:0]    pc;
	logic          pl;
	logic          pe;
	logic          clr;
	logic          exec;
	logic [63:0]   win8;
	logic [CW-1:0] start_idx;

	assign ns = wm_q ? CH_BSLASH : CH_SLASH;
	assign fs = wm_q ? CH_SLASH : CH_BSLASH;

	assign win8 = {win_q[0], win_q[1], win_q[2], win_q[3],
		win_q[4], win_q[5], win_q[6], win_q[7]};

	always_comb begin
		start_idx = '0;
		priority if (wc_q >= CW'(8) && win8 == PFX_FILE3) begin
			start_idx = (wc_q > CW'(9) && win_q[9] == CH_COLON) ? CW'(8) : CW'(7);
		end else if (wm_q && wc_q >= CW'(7) && win8[63:8] == PFX_FILE2) begin
			start_idx = CW'(5);
		end else if (wc_q >= CW'(6) && win8[63:16] == PFX_FILE1) begin
			start_idx = (wc_q > CW'(7) && win_q[7] == CH_COLON) ? CW'(6) : CW'(5);
		end else begin
			start_idx = '0;
		end
	end

	assign src = (cmd == CMD_REP) ? win_q[k_q[IW-1:0]] : cur_q;
	assign hx  = is_hex(src);

	always_comb begin
		em     = 1'b0;
		eb     = '0;
		pp_n   = pp_q;
		done   = 1'b0;
		fhd_ld = 1'b0;
		put    = 1'b0;
		pc     = '0;
		pl     = 1'b0;
		pe     = 1'b0;
		clr    = 1'b0;
		unique case (cmd)
			CMD_BODY, CMD_REP: begin
				unique case (pp_q)
					PP_PCT: begin
						if (hx) begin
							fhd_ld = 1'b1;
							pp_n   = PP_HEX1;
							done   = 1'b1;
						end else begin
							em   = 1'b1;
							eb   = CH_PCT;
							pp_n = PP_NONE;
						end
					end
					PP_HEX1: begin
						em = 1'b1;
						if (hx) begin
							eb   = {hex_val(fhd_q), hex_val(src)};
							pp_n = PP_NONE;
							done = 1'b1;
						end else begin
							eb   = CH_PCT;
							pp_n = PP_FLUSH;
						end
					end
					PP_FLUSH: begin
						em   = 1'b1;
						eb   = fhd_q;
						pp_n = PP_NONE;
					end
					PP_NONE: begin
						done = 1'b1;
						if (src == CH_PCT) begin
							pp_n = PP_PCT;
						end else begin
							em = 1'b1;
							eb = (src == fs) ? ns : src;
						end
					end
				endcase
			end
			CMD_FIN: begin
				unique case (pp_q)
					PP_PCT: begin
						em   = 1'b1;
						eb   = CH_PCT;
						pp_n = PP_NONE;
					end
					PP_HEX1: begin
						em   = 1'b1;
						eb   = CH_PCT;
						pp_n = PP_FLUSH;
					end
					PP_FLUSH: begin
						em   = 1'b1;
						eb   = fhd_q;
						pp_n = PP_NONE;
					end
					PP_NONE: begin
						put = 1'b1;
						if (held_q && le_q == ns) begin
							pc  = le_q;
							pl  = 1'b1;
							clr = 1'b1;
						end else if (held_q) begin
							pc = le_q;
						end else begin
							pc  = ns;
							pl  = 1'b1;
							clr = 1'b1;
						end
					end
				endcase
			end
			CMD_FIN2: begin
				put = 1'b1;
				pc  = ns;
				pl  = 1'b1;
				clr = 1'b1;
			end
			CMD_EMPTY: begin
				put = 1'b1;
				pl  = 1'b1;
				pe  = 1'b1;
				clr = 1'b1;
			end
			default: ;
		endcase
		if (em && held_q) begin
			put = 1'b1;
			pc  = le_q;
		end
	end

	// a step that pushes a result waits while the output register is full and not taken
	assign exec = !put || !ov_q || out_ready;

	always_comb begin
		stat           = '0;
		stat.ok        = exec;
		stat.byte_done = done;
		stat.start_end = start_idx >= wc_q;
		stat.k_end     = CW'(k_q + 1'b1) >= wc_q;
		stat.in_body   = body_q;
		stat.wc_zero   = wc_q == '0;
		stat.win_full  = CW'(wc_q + 1'b1) >= CW'(PREFIX_WINDOW);
		stat.pp_zero   = pp_q == PP_NONE;
		stat.fin_two   = held_q && le_q != ns;
		stat.end_flag  = last_q || end_q;
		stat.new_last  = last_in;
		stat.new_end   = end_only;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q   <= '0;
			body_q <= 1'b0;
			pp_q   <= PP_NONE;
			held_q <= 1'b0;
			ov_q   <= 1'b0;
			wm_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				wm_q <= cfg_wdata;
			end
			if (put && exec) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			if (cmd == CMD_LOAD && !end_only && !body_q) begin
				wc_q <= CW'(wc_q + 1'b1);
			end
			if (cmd == CMD_START) begin
				body_q <= 1'b1;
			end
			if (exec) begin
				if (clr) begin
					wc_q   <= '0;
					body_q <= 1'b0;
					pp_q   <= PP_NONE;
					held_q <= 1'b0;
				end else begin
					pp_q <= pp_n;
					if (em) begin
						held_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd == CMD_LOAD) begin
			cur_q  <= char_in;
			last_q <= last_in;
			end_q  <= end_only;
			if (!end_only && !body_q) begin
				win_q[wc_q[IW-1:0]] <= char_in;
			end
		end
		if (cmd == CMD_START) begin
			k_q <= start_idx;
		end
		if (exec) begin
			if (fhd_ld) begin
				fhd_q <= src;
			end
			if (em) begin
				le_q <= eb;
			end
			if (cmd == CMD_REP && done) begin
				k_q <= CW'(k_q + 1'b1);
			end
			if (put) begin
				oc_q <= pc;
				ol_q <= pl;
				oe_q <= pe;
			end
		end
	end

	assign out_valid    = ov_q;
	assign char_out     = oc_q;
	assign last_out     = ol_q;
	assign empty_string = oe_q;

endmodule

[sv/upd_ctrl.sv]
// Controller: sequences accept, prefix replay, body steps and string end.
// Depends on upd_pkg; commands upd_datapath and reads its status.
module upd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  upd_pkg::upd_stat_t stat,
	output upd_pkg::upd_cmd_e  cmd
);
	import upd_pkg::*;

	upd_state_e state_q;
	upd_state_e state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n  = state_q;
		cmd      = CMD_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd = CMD_LOAD;
					if (stat.new_end) begin
						if (!stat.in_body && stat.wc_zero) begin
							state_n = ST_EMPTY;
						end else if (!stat.in_body) begin
							state_n = ST_START;
						end else begin
							state_n = ST_FIN;
						end
					end else if (!stat.in_body) begin
						if (stat.win_full || stat.new_last) begin
							state_n = ST_START;
						end
					end else begin
						state_n = ST_BODY;
					end
				end
			end
			ST_START: begin
				cmd = CMD_START;
				if (!stat.start_end) begin
					state_n = ST_REPLAY;
				end else if (stat.end_flag) begin
					state_n = ST_FIN;
				end else begin
					state_n = ST_IDLE;
				end
			end
			ST_REPLAY: begin
				cmd = CMD_REP;
				if (stat.ok && stat.byte_done && stat.k_end) begin
					state_n = stat.end_flag ? ST_FIN : ST_IDLE;
				end
			end
			ST_BODY: begin
				cmd = CMD_BODY;
				if (stat.ok && stat.byte_done) begin
					state_n = stat.end_flag ? ST_FIN : ST_IDLE;
				end
			end
			ST_FIN: begin
				cmd = CMD_FIN;
				if (stat.ok && stat.pp_zero) begin
					state_n = stat.fin_two ? ST_FIN2 : ST_IDLE;
				end
			end
			ST_FIN2: begin
				cmd = CMD_FIN2;
				if (stat.ok) begin
					state_n = ST_IDLE;
				end
			end
			ST_EMPTY: begin
				cmd = CMD_EMPTY;
				if (stat.ok) begin
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

endmodule

[sv/uri_path_percent_decoder.sv]
// Top level of the URI path percent decoder: controller plus datapath.
// Depends on upd_pkg, upd_ifs, upd_ctrl and upd_datapath.
//
//   channel   dir   payload                               handshake
//   uri       in    char_in[8] last_in end_only           valid/ready
//   path      out   char_out[8] last_out empty_string     valid/ready
//   cfg       in    cfg_wdata (windows_mode)              cfg_we, no wait
//
// A prefix byte that does not fill the window is only accepted; a body byte is
// accepted, then decoded in the body state, which stays longer while a broken escape
// is flushed. Filling the window adds the start state plus the replay state for each
// held byte. String end adds the finishing states. Reset clears all control state at once.
// Results leave through one output register; a step that pushes a result
// waits while that register is full and not taken.
module uri_path_percent_decoder #(
	parameter int unsigned PREFIX_WINDOW = 10
) (
	input  logic      clk,
	input  logic      arst_n,
	upd_in_if.sink    uri,
	upd_out_if.source path,
	input  logic      cfg_we,
	input  logic      cfg_wdata
);
	import upd_pkg::*;

	upd_cmd_e  cmd;
	upd_stat_t stat;

	upd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (uri.valid),
		.in_ready (uri.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	upd_datapath #(
		.PREFIX_WINDOW (PREFIX_WINDOW)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.char_in      (uri.char_in),
		.last_in      (uri.last_in),
		.end_only     (uri.end_only),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.out_ready    (path.ready),
		.out_valid    (path.valid),
		.char_out     (path.char_out),
		.last_out     (path.last_out),
		.empty_string (path.empty_string)
	);

endmodule

[sv/upd_checker.sv]
// Port-level checks of the URI path percent decoder, bound to the top level.
// Depends on upd_pkg and uri_path_percent_decoder.
module upd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       uri_valid,
	input logic       uri_ready,
	input logic       uri_last_in,
	input logic       uri_end_only,
	input logic       path_valid,
	input logic       path_ready,
	input logic [7:0] path_char_out,
	input logic       path_last_out,
	input logic       path_empty_string
);
	import upd_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		path_valid && !path_ready |=> path_valid && $stable(path_char_out) &&
			$stable(path_last_out) && $stable(path_empty_string))
		else $error("path item changed while stalled");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		path_valid && path_empty_string |-> path_last_out && path_char_out == 8'h00)
		else $error("empty flag item malformed");

	a_final_sep: assert property (@(posedge clk) disable iff (!arst_n)
		path_valid && path_last_out && !path_empty_string |->
			path_char_out == CH_SLASH || path_char_out == CH_BSLASH)
		else $error("final path byte is not a separator");

	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		uri_valid && uri_ready && (uri_last_in || uri_end_only) |=> !uri_ready)
		else $error("ready held after string end");

endmodule

bind uri_path_percent_decoder upd_checker u_upd_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.uri_valid         (uri.valid),
	.uri_ready         (uri.ready),
	.uri_last_in       (uri.last_in),
	.uri_end_only      (uri.end_only),
	.path_valid        (path.valid),
	.path_ready        (path.ready),
	.path_char_out     (path.char_out),
	.path_last_out     (path.last_out),
	.path_empty_string (path.empty_string)
);

[tb/upd_path_checker.sv]
// Scoreboard for the URI path percent decoder: predicts the path items from accepted URI items
// and checks each path item against the oldest prediction.
// Depends on upd_pkg and the upd_in_if / upd_out_if interfaces.
module upd_path_checker (
	input  logic clk,
	input  logic arst_n,
	upd_in_if    uri,
	upd_out_if   path,
	input  logic cfg_we,
	input  logic cfg_wdata,
	output int   fails,
	output int   outstanding
);
	import upd_pkg::*;

	localparam int WIN = 10;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       empty;
	} path_beat_t;

	path_beat_t path_due[$];
	logic [7:0] win_buf[WIN];
	int         win_len;
	logic       body_phase;
	upd_pp_e    esc;
	logic [7:0] esc_digit;
	logic [7:0] held_byte;
	logic       held_ok;
	logic       win_mode;

	function automatic logic [7:0] home_sep();
		return win_mode ? CH_BSLASH : CH_SLASH;
	endfunction

	function automatic logic [7:0] away_sep();
		return win_mode ? CH_SLASH : CH_BSLASH;
	endfunction

	// -1 when not a hex digit
	function automatic int nib(input logic [7:0] c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "a" && c <= "f") return c - "a" + 10;
		if (c >= "A" && c <= "F") return c - "A" + 10;
		return -1;
	endfunction

	function automatic void note(input logic [7:0] c, input logic l, input logic e);
		path_due.push_back('{ch: c, last: l, empty: e});
	endfunction

	// one byte of delay so the final byte can carry last_out
	function automatic void put_path(input logic [7:0] b);
		if (held_ok) note(held_byte, 1'b0, 1'b0);
		held_byte = b;
		held_ok = 1'b1;
	endfunction

	function automatic void wipe();
		foreach (win_buf[i]) win_buf[i] = 8'h00;
		win_len = 0;
		body_phase = 1'b0;
		esc = PP_NONE;
		esc_digit = 8'h00;
		held_byte = 8'h00;
		held_ok = 1'b0;
	endfunction

	function automatic void body_char(input logic [7:0] c);
		int hi;
		int lo;
		if (esc == PP_PCT) begin
			if (nib(c) >= 0) begin
				esc_digit = c;
				esc = PP_HEX1;
				return;
			end
			put_path(CH_PCT);
			esc = PP_NONE;
		end else if (esc == PP_HEX1) begin
			if (nib(c) >= 0) begin
				hi = nib(esc_digit);
				lo = nib(c);
				put_path({hi[3:0], lo[3:0]});
				esc = PP_NONE;
				return;
			end
			put_path(CH_PCT);
			put_path(esc_digit);
			esc = PP_NONE;
		end
		if (c == CH_PCT) begin
			esc = PP_PCT;
		end else if (c == away_sep()) begin
			put_path(home_sep());
		end else begin
			put_path(c);
		end
	endfunction

	// pfx is right-aligned, n bytes long
	function automatic logic win_starts(input logic [63:0] pfx, input int n);
		if (win_len < n) return 1'b0;
		for (int i = 0; i < n; i++) begin
			if (win_buf[i] != pfx[8*(n-1-i) +: 8]) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic logic colon_at(input int idx);
		return idx < win_len && win_buf[idx] == CH_COLON;
	endfunction

	function automatic void open_body();
		int skip;
		skip = 0;
		if (win_starts(PFX_FILE3, 8)) begin
			skip = colon_at(9) ? 8 : 7;
		end else if (win_mode && win_starts(PFX_FILE2, 7)) begin
			skip = 5;
		end else if (win_starts(PFX_FILE1, 6)) begin
			skip = colon_at(7) ? 6 : 5;
		end
		body_phase = 1'b1;
		for (int k = skip; k < win_len; k++) body_char(win_buf[k]);
	endfunction

	function automatic void close_string();
		logic two;
		if (!body_phase) open_body();
		if (esc != PP_NONE) begin
			two = (esc == PP_HEX1);
			esc = PP_NONE;
			put_path(CH_PCT);
			if (two) put_path(esc_digit);
		end
		if (held_ok && held_byte == home_sep()) begin
			note(held_byte, 1'b1, 1'b0);
		end else begin
			if (held_ok) note(held_byte, 1'b0, 1'b0);
			note(home_sep(), 1'b1, 1'b0);
		end
		wipe();
	endfunction

	function automatic void take_item(input logic [7:0] c, input logic l, input logic e);
		if (e) begin
			if (!body_phase && win_len == 0) begin
				note(8'h00, 1'b1, 1'b1);
				wipe();
			end else begin
				close_string();
			end
			return;
		end
		if (!body_phase) begin
			if (win_len < WIN) begin
				win_buf[win_len] = c;
				win_len++;
			end
			if (win_len >= WIN) open_body();
		end else begin
			body_char(c);
		end
		if (l) close_string();
	endfunction

	task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
		if (fails < 200) $display("%0t path %s: got %02h, want %02h", $time, what, got, want);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		path_beat_t want;
		if (!arst_n) begin
			win_mode = 1'b0;
			wipe();
			path_due.delete();
			fails = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) win_mode = cfg_wdata;
			if (uri.valid && uri.ready) take_item(uri.char_in, uri.last_in, uri.end_only);
			if (path.valid && path.ready) begin
				if (path_due.size() == 0) begin
					report("item with none due", path.char_out, 8'h00);
				end else begin
					want = path_due.pop_front();
					if (path.char_out !== want.ch) report("char_out", path.char_out, want.ch);
					if (path.last_out !== want.last)
						report("last_out", 8'(path.last_out), 8'(want.last));
					if (path.empty_string !== want.empty)
						report("empty_string", 8'(path.empty_string), 8'(want.empty));
				end
			end
			outstanding <= path_due.size();
		end
	end

endmodule

[tb/tb_uri_path_percent_decoder.sv]
// Testbench top for the URI path percent decoder: clock, reset, URI stimulus, path back-pressure
// and the verdict. Depends on upd_pkg, upd_ifs, the decoder and upd_path_checker.
module tb_uri_path_percent_decoder;
	import upd_pkg::*;

	localparam int HOLD_LEN   = 300;
	localparam int IDLE_LIMIT = 2000;
	localparam int GAP_PCT    = 17;

	typedef logic [7:0] uri_text_t[$];

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	int   fails;
	int   outstanding;
	int   items_sent = 0;
	int   quiet;
	bit   calm = 1'b0;
	bit   hold_off = 1'b0;

	upd_in_if  uri_ch();
	upd_out_if path_ch();

	uri_path_percent_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.uri      (uri_ch),
		.path     (path_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	upd_path_checker scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.uri        (uri_ch),
		.path       (path_ch),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fails      (fails),
		.outstanding(outstanding)
	);

	always #5 clk = ~clk;

	function automatic uri_text_t text(input string s);
		uri_text_t u;
		foreach (s[i]) u.push_back(s[i]);
		return u;
	endfunction

	function automatic logic [7:0] hex_char();
		string hex_set;
		hex_set = "0123456789abcdefABCDEF";
		return hex_set[$urandom_range(0, 21)];
	endfunction

	// mostly well-formed URIs with random bodies, some plain noise
	function automatic uri_text_t make_uri(input int body_max);
		uri_text_t u;
		string     pfx;
		int        n;
		if ($urandom_range(0, 99) < 15) begin
			n = $urandom_range(0, 12);
			repeat (n) u.push_back(8'($urandom_range(0, 255)));
			return u;
		end
		case ($urandom_range(0, 7))
			0, 1:    pfx = "file:///";
			2, 3:    pfx = "file://";
			4:       pfx = "file:/";
			5:       pfx = "file:";
			default: pfx = "";
		endcase
		foreach (pfx[i]) u.push_back(pfx[i]);
		if ($urandom_range(0, 2) == 0) begin
			u.push_back(8'($urandom_range(8'h61, 8'h7a)));
			u.push_back(CH_COLON);
		end
		n = $urandom_range(0, body_max);
		repeat (n) begin
			case ($urandom_range(0, 9))
				0: u.push_back(8'($urandom_range(0, 255)));
				1: u.push_back(CH_SLASH);
				2: u.push_back(CH_BSLASH);
				3: begin
					u.push_back(CH_PCT);
					u.push_back(hex_char());
					u.push_back(hex_char());
				end
				4: begin
					u.push_back(CH_PCT);
					if ($urandom_range(0, 1)) u.push_back(hex_char());
					u.push_back($urandom_range(0, 1) ? CH_PCT : 8'($urandom_range(8'h80, 8'hff)));
				end
				5: u.push_back(CH_PCT);
				6: u.push_back(hex_char());
				7: u.push_back(CH_COLON);
				default: u.push_back(8'($urandom_range(8'h67, 8'h7a)));
			endcase
		end
		return u;
	endfunction

	task automatic send_item(input logic [7:0] c, input logic l, input logic e);
		while (!calm && $urandom_range(0, 99) < GAP_PCT) begin
			uri_ch.valid <= 1'b0;
			@(posedge clk);
		end
		uri_ch.valid    <= 1'b1;
		uri_ch.char_in  <= c;
		uri_ch.last_in  <= l;
		uri_ch.end_only <= e;
		do @(posedge clk); while (!uri_ch.ready);
		items_sent++;
	endtask

	// ends on last_in with the final byte, or on a separate end_only item
	task automatic send_uri(input uri_text_t s, input bit end_token, input bit end_last);
		if (s.size() == 0) end_token = 1'b1;
		foreach (s[i]) send_item(s[i], !end_token && i == s.size() - 1, 1'b0);
		if (end_token) send_item(8'($urandom_range(0, 255)), end_last, 1'b1);
	endtask

	task automatic run_strings(input int goal, input int body_max);
		int stop;
		stop = items_sent + goal;
		while (items_sent < stop)
			send_uri(make_uri(body_max), $urandom_range(0, 4) == 0, $urandom_range(0, 1));
		uri_ch.valid <= 1'b0;
	endtask

	task automatic settle();
		do @(posedge clk); while (outstanding != 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		path_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				path_ch.ready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
				hold_off = 1'b0;
			end
			path_ch.ready <= calm || $urandom_range(0, 99) >= GAP_PCT;
		end
	end

	initial begin
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((uri_ch.valid && uri_ch.ready) || (path_ch.valid && path_ch.ready)) quiet = 0;
			else quiet++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		uri_ch.valid    <= 1'b0;
		uri_ch.char_in  <= 8'h00;
		uri_ch.last_in  <= 1'b0;
		uri_ch.end_only <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_wdata       <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_mode(1'b0);

		// empty string, escape cut short at end, byte extremes, broken escape,
		// short prefix, path already ending in a separator
		send_uri(text(""), 1'b1, 1'b0);
		send_uri(text("%4"), 1'b1, 1'b0);
		send_uri({8'h00, 8'hff}, 1'b0, 1'b0);
		send_uri(text("%z%41\\"), 1'b0, 1'b0);
		send_uri(text("file:/x"), 1'b0, 1'b0);
		send_uri(text("/"), 1'b0, 1'b0);
		uri_ch.valid <= 1'b0;
		settle();

		write_mode(1'b1);
		run_strings(40, 12);
		settle();

		write_mode(1'b0);
		calm = 1'b1;
		run_strings(40, 12);
		calm = 1'b0;
		settle();

		write_mode(1'b1);
		hold_off = 1'b1;
		run_strings(35, 30);
		settle();

		if (fails == 0 && outstanding == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
